// File: sv/rgb_to_ycbcr_2x2_downsample_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 2x2 downsampling colour converter
// Shared shorthands for the concurrent checks on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_YCBCR_2X2_DOWNSAMPLE_CORE_MACROS_SVH
`define RGB_TO_YCBCR_2X2_DOWNSAMPLE_CORE_MACROS_SVH

// The consequent is checked in the same cycle as the antecedent.
`define RYDS_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ryds check failed");

// The consequent is checked in the cycle after the antecedent.
`define RYDS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ryds check failed");

`endif

// File: sv/ryds_pkg.sv
// ----------------------------------------------------------------------------
// ryds_pkg
// Types, constants and a helper function shared by the converter modules.
// ----------------------------------------------------------------------------
package ryds_pkg;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  localparam int CFG_W       = 12;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

  // Register indexes, taken from paddr[2].
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam int PAIR_W  = 9;
  localparam int SUM_W   = 10;
  localparam int COEF_W  = 13;
  localparam int PROD_W  = SUM_W + COEF_W;
  localparam int ACC_W   = 25;
  localparam int ENTRY_W = 3 * PAIR_W;

  // Q13 coefficient magnitudes; signs are applied when the products are combined.
  localparam logic [COEF_W-1:0] COEF_Y_R  = 13'd2105;
  localparam logic [COEF_W-1:0] COEF_Y_G  = 13'd4129;
  localparam logic [COEF_W-1:0] COEF_Y_B  = 13'd803;
  localparam logic [COEF_W-1:0] COEF_CB_R = 13'd1212;
  localparam logic [COEF_W-1:0] COEF_CB_G = 13'd2384;
  localparam logic [COEF_W-1:0] COEF_CB_B = 13'd3596;
  localparam logic [COEF_W-1:0] COEF_CR_R = 13'd3596;
  localparam logic [COEF_W-1:0] COEF_CR_G = 13'd3015;
  localparam logic [COEF_W-1:0] COEF_CR_B = 13'd582;

  localparam logic signed [10:0] LUMA_OFFSET   = 11'sd16;
  localparam logic signed [10:0] CHROMA_OFFSET = 11'sd128;

  // Four-pixel channel sums of one block.
  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } block_sum_t;

  // Divide by 32768 with truncation toward zero, add the offset and clamp to a byte.
  function automatic logic [7:0] finish(input logic signed [ACC_W-1:0] acc,
                                        input logic signed [10:0] offset);
    logic signed [9:0]  quot;
    logic signed [10:0] biased;
    logic [7:0]         res;
    quot = $signed(acc[ACC_W-1:15]);
    if (acc[ACC_W-1] && (acc[14:0] != 15'd0)) begin
      quot = quot + 10'sd1;
    end
    biased = {quot[9], quot} + offset;
    if (biased < 11'sd0) begin
      res = 8'd0;
    end else if (biased > 11'sd255) begin
      res = 8'd255;
    end else begin
      res = biased[7:0];
    end
    return res;
  endfunction

endpackage

// File: sv/ryds_ram.sv
// ----------------------------------------------------------------------------
// ryds_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module ryds_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/ryds_matrix.sv
// ----------------------------------------------------------------------------
// ryds_matrix
// Colour matrix: constant products in one stage, then sums, scaling and
// saturation into the output register.
// ----------------------------------------------------------------------------
module ryds_matrix (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ryds_pkg::block_sum_t in_sum,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_luma,
  output logic [7:0]          out_chroma_blue,
  output logic [7:0]          out_chroma_red
);

  localparam int PW = ryds_pkg::PROD_W;
  localparam int AW = ryds_pkg::ACC_W;

  logic          prod_valid;
  logic [PW-1:0] p_y_r, p_y_g, p_y_b;
  logic [PW-1:0] p_cb_r, p_cb_g, p_cb_b;
  logic [PW-1:0] p_cr_r, p_cr_g, p_cr_b;
  logic          out_free;
  logic          prod_ready;
  logic signed [AW-1:0] acc_y, acc_cb, acc_cr;

  assign out_free   = !out_valid || out_ready;
  assign prod_ready = !prod_valid || out_free;
  assign in_ready   = prod_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (prod_ready) begin
      prod_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_ready && in_valid) begin
      p_y_r  <= PW'(in_sum.red)   * PW'(ryds_pkg::COEF_Y_R);
      p_y_g  <= PW'(in_sum.green) * PW'(ryds_pkg::COEF_Y_G);
      p_y_b  <= PW'(in_sum.blue)  * PW'(ryds_pkg::COEF_Y_B);
      p_cb_r <= PW'(in_sum.red)   * PW'(ryds_pkg::COEF_CB_R);
      p_cb_g <= PW'(in_sum.green) * PW'(ryds_pkg::COEF_CB_G);
      p_cb_b <= PW'(in_sum.blue)  * PW'(ryds_pkg::COEF_CB_B);
      p_cr_r <= PW'(in_sum.red)   * PW'(ryds_pkg::COEF_CR_R);
      p_cr_g <= PW'(in_sum.green) * PW'(ryds_pkg::COEF_CR_G);
      p_cr_b <= PW'(in_sum.blue)  * PW'(ryds_pkg::COEF_CR_B);
    end
  end

  always_comb begin
    acc_y  = $signed(AW'(p_y_r)) + $signed(AW'(p_y_g)) + $signed(AW'(p_y_b));
    acc_cb = $signed(AW'(p_cb_b)) - $signed(AW'(p_cb_r)) - $signed(AW'(p_cb_g));
    acc_cr = $signed(AW'(p_cr_r)) - $signed(AW'(p_cr_g)) - $signed(AW'(p_cr_b));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && prod_valid) begin
      out_luma        <= ryds_pkg::finish(acc_y,  ryds_pkg::LUMA_OFFSET);
      out_chroma_blue <= ryds_pkg::finish(acc_cb, ryds_pkg::CHROMA_OFFSET);
      out_chroma_red  <= ryds_pkg::finish(acc_cr, ryds_pkg::CHROMA_OFFSET);
    end
  end

endmodule

// File: sv/rgb_to_ycbcr_2x2_downsample_core.sv
// ----------------------------------------------------------------------------
// rgb_to_ycbcr_2x2_downsample_core
// RGB pixels in raster order to one averaged BT.601 Y/Cb/Cr item per 2x2 block.
//
//   Channel   Direction  Item
//   s_axis    in         one RGB pixel, raster order
//   m_axis    out        one Y, Cb, Cr triple per 2x2 block
//   apb       in/out     image_width at 0x0, image_height at 0x4
//
// One pixel is taken every cycle while s_tready is high; a block result reaches m_axis
// through the block sum register (loaded at the edge that takes its last pixel, in
// step with the line store read) and then the two matrix registers.
// The line store of horizontal pair sums is not cleared by reset; every entry
// is written on an even row before the odd row reads it.
// Back-pressure on m_axis stalls the pipeline, and s_tready drops only when
// every stage holds an item.
// Any register write restarts the frame at row 0, column 0.
// ----------------------------------------------------------------------------
module rgb_to_ycbcr_2x2_downsample_core #(
  parameter int MAX_WIDTH  = ryds_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ryds_pkg::DEF_MAX_HEIGHT
) (
  input  logic                         clk,
  input  logic                         rst,
  // Pixel input: red [7:0], green [15:8], blue [23:16].
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [23:0]                  s_tdata,
  // Block output: luma [7:0], chroma_blue [15:8], chroma_red [23:16].
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [23:0]                  m_tdata,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ryds_pkg::PADDR_W-1:0] paddr,
  input  logic [ryds_pkg::PDATA_W-1:0] pwdata,
  output logic [ryds_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  localparam int CFG_W      = ryds_pkg::CFG_W;
  localparam int PAIR_W     = ryds_pkg::PAIR_W;
  localparam int SUM_W      = ryds_pkg::SUM_W;
  localparam int ENTRY_W    = ryds_pkg::ENTRY_W;
  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int LA_W       = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int EW_W       = $clog2(MAX_WIDTH + 1);
  localparam int EH_W       = $clog2(MAX_HEIGHT + 1);
  localparam int CW_W       = (EW_W > CFG_W) ? EW_W : CFG_W;
  localparam int CH_W       = (EH_W > CFG_W) ? EH_W : CFG_W;

  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic             cfg_write;

  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;
  logic [23:0]      left_pixel_hold;

  logic [CW_W-1:0]  eff_width, width_ext;
  logic [CH_W-1:0]  eff_height, height_ext;
  logic             col_last, row_last;
  logic             accept;
  logic [7:0]       pix_r, pix_g, pix_b;
  logic             have_pair;
  logic [PAIR_W-1:0] pair_r, pair_g, pair_b;
  logic [ENTRY_W-1:0] pair_entry;
  logic [COL_W-1:0] pair_index;
  logic [LA_W-1:0]  line_addr;
  logic             line_wr, line_rd, emit;
  logic [ENTRY_W-1:0] line_q;

  logic               s1_valid, s1_ready, s1_use_line;
  logic [ENTRY_W-1:0] s1_pair;
  ryds_pkg::block_sum_t s1_sum;
  logic               mat_ready;

  // ---- configuration port ----
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= ryds_pkg::WIDTH_RESET;
      image_height <= ryds_pkg::HEIGHT_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        ryds_pkg::REG_IMAGE_WIDTH:  image_width  <= pwdata[CFG_W-1:0];
        ryds_pkg::REG_IMAGE_HEIGHT: image_height <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      ryds_pkg::REG_IMAGE_WIDTH:  prdata = ryds_pkg::PDATA_W'(image_width);
      ryds_pkg::REG_IMAGE_HEIGHT: prdata = ryds_pkg::PDATA_W'(image_height);
      default:                    prdata = '0;
    endcase
  end

  // A zero dimension acts as one, and one above the maximum acts as the maximum.
  always_comb begin
    width_ext  = CW_W'(image_width);
    height_ext = CH_W'(image_height);
    if (width_ext == '0) begin
      eff_width = CW_W'(1);
    end else if (width_ext > CW_W'(MAX_WIDTH)) begin
      eff_width = CW_W'(MAX_WIDTH);
    end else begin
      eff_width = width_ext;
    end
    if (height_ext == '0) begin
      eff_height = CH_W'(1);
    end else if (height_ext > CH_W'(MAX_HEIGHT)) begin
      eff_height = CH_W'(MAX_HEIGHT);
    end else begin
      eff_height = height_ext;
    end
  end

  assign col_last = (CW_W'(column_count) + CW_W'(1)) == eff_width;
  assign row_last = (CH_W'(row_count) + CH_W'(1)) == eff_height;

  // ---- pixel intake and pair forming ----
  assign accept = s_tvalid && s_tready;
  assign pix_r  = s_tdata[7:0];
  assign pix_g  = s_tdata[15:8];
  assign pix_b  = s_tdata[23:16];

  always_comb begin
    if (!column_count[0]) begin
      // Even column: a pair exists only when this is the last column of an odd-width row.
      have_pair = col_last;
      pair_r    = {pix_r, 1'b0};
      pair_g    = {pix_g, 1'b0};
      pair_b    = {pix_b, 1'b0};
    end else begin
      have_pair = 1'b1;
      pair_r    = PAIR_W'(left_pixel_hold[23:16]) + PAIR_W'(pix_r);
      pair_g    = PAIR_W'(left_pixel_hold[15:8])  + PAIR_W'(pix_g);
      pair_b    = PAIR_W'(left_pixel_hold[7:0])   + PAIR_W'(pix_b);
    end
  end

  assign pair_entry = {pair_r, pair_g, pair_b};
  assign pair_index = column_count >> 1;
  assign line_addr  = pair_index[LA_W-1:0];
  assign line_wr    = accept && have_pair && !row_count[0];
  assign line_rd    = accept && have_pair && row_count[0];
  assign emit       = have_pair && (row_count[0] || row_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count    <= '0;
      row_count       <= '0;
      left_pixel_hold <= '0;
    end else if (cfg_write) begin
      column_count    <= '0;
      row_count       <= '0;
      left_pixel_hold <= '0;
    end else if (accept) begin
      if (!column_count[0]) begin
        left_pixel_hold <= {pix_r, pix_g, pix_b};
      end
      if (col_last) begin
        column_count <= '0;
        row_count    <= row_last ? '0 : row_count + ROW_W'(1);
      end else begin
        column_count <= column_count + COL_W'(1);
      end
    end
  end

  ryds_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (LINE_DEPTH),
    .AW    (LA_W)
  ) u_line (
    .clk     (clk),
    .wr_en   (line_wr),
    .wr_addr (line_addr),
    .wr_data (pair_entry),
    .rd_en   (line_rd),
    .rd_addr (line_addr),
    .rd_data (line_q)
  );

  // ---- block sum stage, lined up with the line store read data ----
  assign s1_ready = !s1_valid || mat_ready;
  assign s_tready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= s_tvalid && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pair     <= pair_entry;
      s1_use_line <= row_count[0];
    end
  end

  always_comb begin
    if (s1_use_line) begin
      s1_sum.red   = SUM_W'(line_q[26:18]) + SUM_W'(s1_pair[26:18]);
      s1_sum.green = SUM_W'(line_q[17:9])  + SUM_W'(s1_pair[17:9]);
      s1_sum.blue  = SUM_W'(line_q[8:0])   + SUM_W'(s1_pair[8:0]);
    end else begin
      // Last row of an odd height: the pair is doubled.
      s1_sum.red   = {s1_pair[26:18], 1'b0};
      s1_sum.green = {s1_pair[17:9], 1'b0};
      s1_sum.blue  = {s1_pair[8:0], 1'b0};
    end
  end

  ryds_matrix u_matrix (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (s1_valid),
    .in_ready        (mat_ready),
    .in_sum          (s1_sum),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_luma        (m_tdata[7:0]),
    .out_chroma_blue (m_tdata[15:8]),
    .out_chroma_red  (m_tdata[23:16])
  );

endmodule

// File: sv/ryds_checker.sv
// ----------------------------------------------------------------------------
// ryds_checker
// Port-level checks on the converter, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "rgb_to_ycbcr_2x2_downsample_core_macros.svh"

module ryds_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [23:0]                  m_tdata,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [ryds_pkg::PADDR_W-1:0] paddr,
  input logic [ryds_pkg::PDATA_W-1:0] pwdata,
  input logic [ryds_pkg::PDATA_W-1:0] prdata,
  input logic                         pready
);

  logic cfg_write;
  assign cfg_write = psel && penable && pwrite && pready;

  // A stalled result holds its value.
  `RYDS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // With the output register empty the pipeline cannot be full.
  `RYDS_ASSERT_IMPL(a_ready_when_empty, !m_tvalid, s_tready)

  // A register reads back what was last written to it.
  `RYDS_ASSERT_NEXT(a_readback, cfg_write, (paddr[2] != $past(paddr[2])) || (prdata[11:0] == $past(pwdata[11:0])))

  // Registers are 12 bits wide; the upper read bits stay zero.
  `RYDS_ASSERT_IMPL(a_prdata_upper, psel, prdata[31:12] == 20'd0)

endmodule

bind rgb_to_ycbcr_2x2_downsample_core ryds_checker u_ryds_checker (.*);

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the 2x2 downsampling RGB to YCbCr converter
// Streams RGB pixels through the core under a range of frame sizes and predicts
// the averaged Y, Cb, Cr item of every 2x2 block. Each block item from the core
// is compared field by field with the oldest prediction. The sender idles in
// random bursts and the receiver stalls to a changing pattern.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LINE_ENTRIES = 1024;
  localparam int DIM_MAX      = 2048;
  localparam int IDLE_LIMIT   = 4000;
  localparam int RANDOM_ITEMS = 1100;

  // One block item as it appears on m_tdata, luma in the low byte.
  typedef struct packed {
    logic [7:0] chroma_red;
    logic [7:0] chroma_blue;
    logic [7:0] luma;
  } ycc_t;

  typedef enum logic [1:0] {
    RX_ALWAYS, RX_RANDOM, RX_SPARSE, RX_RUNS
  } rx_mode_t;

  // Predicts the block items from the accepted pixels and checks the core's output.
  class ycbcr_block_tracker;
    logic [11:0] width_reg;
    logic [11:0] height_reg;
    logic [26:0] pair_line [0:LINE_ENTRIES-1];
    logic [7:0]  held_r, held_g, held_b;
    int unsigned col, row;
    ycc_t        due_blocks[$];
    int unsigned blocks_checked;

    function new();
      width_reg  = 12'd640;
      height_reg = 12'd480;
      blocks_checked = 0;
      restart();
    endfunction

    function void restart();
      held_r = 8'd0;
      held_g = 8'd0;
      held_b = 8'd0;
      col = 0;
      row = 0;
    endfunction

    function void write_register(logic idx, logic [31:0] value);
      if (idx == ryds_pkg::REG_IMAGE_WIDTH) begin
        width_reg = value[11:0];
      end else begin
        height_reg = value[11:0];
      end
      restart();
    endfunction

    function int unsigned clamp_dim(logic [11:0] v);
      int unsigned d;
      d = 32'(v);
      if (d == 0) d = 1;
      if (d > DIM_MAX) d = DIM_MAX;
      return d;
    endfunction

    function logic [7:0] to_byte(int v);
      if (v < 0) return 8'd0;
      if (v > 255) return 8'd255;
      return v[7:0];
    endfunction

    // Sums are four-pixel channel sums; division truncates toward zero.
    function ycc_t convert(int sr, int sg, int sb);
      ycc_t res;
      int   yv, cbv, crv;
      yv  = 2105 * sr + 4129 * sg + 803 * sb;
      cbv = -1212 * sr - 2384 * sg + 3596 * sb;
      crv = 3596 * sr - 3015 * sg - 582 * sb;
      res.luma        = to_byte(yv / 32768 + 16);
      res.chroma_blue = to_byte(cbv / 32768 + 128);
      res.chroma_red  = to_byte(crv / 32768 + 128);
      return res;
    endfunction

    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int unsigned w, h, p;
      int          pr, pg, pb;
      bit          have_pair;
      logic [26:0] e;
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      have_pair = 1'b0;
      pr = 0;
      pg = 0;
      pb = 0;
      if (col[0] == 1'b0) begin
        held_r = r;
        held_g = g;
        held_b = b;
        // A lone pixel at the end of an odd-width row pairs with itself.
        if (col + 1 >= w) begin
          pr = 2 * int'(r);
          pg = 2 * int'(g);
          pb = 2 * int'(b);
          have_pair = 1'b1;
        end
      end else begin
        pr = int'(held_r) + int'(r);
        pg = int'(held_g) + int'(g);
        pb = int'(held_b) + int'(b);
        have_pair = 1'b1;
      end
      if (have_pair) begin
        p = col >> 1;
        if (p >= LINE_ENTRIES) p = LINE_ENTRIES - 1;
        if (row[0] == 1'b0) begin
          pair_line[p] = {pr[8:0], pg[8:0], pb[8:0]};
          // The last row of an odd-height frame forms its block on its own.
          if (row + 1 >= h) due_blocks.push_back(convert(2 * pr, 2 * pg, 2 * pb));
        end else begin
          e = pair_line[p];
          due_blocks.push_back(convert(int'(e[26:18]) + pr, int'(e[17:9]) + pg,
                                       int'(e[8:0]) + pb));
        end
      end
      col++;
      if (col >= w) begin
        col = 0;
        row++;
        if (row >= h) row = 0;
      end
    endfunction

    // Returns an empty string when the item matches the oldest prediction.
    function string check_block(ycc_t got);
      ycc_t  want;
      string msg;
      if (due_blocks.size() == 0) return $sformatf("block item %h with none predicted", got);
      want = due_blocks.pop_front();
      blocks_checked++;
      msg = "";
      if (got.luma != want.luma)
        msg = {msg, $sformatf(" luma %0d/%0d", got.luma, want.luma)};
      if (got.chroma_blue != want.chroma_blue)
        msg = {msg, $sformatf(" chroma_blue %0d/%0d", got.chroma_blue, want.chroma_blue)};
      if (got.chroma_red != want.chroma_red)
        msg = {msg, $sformatf(" chroma_red %0d/%0d", got.chroma_red, want.chroma_red)};
      if (msg != "") msg = {$sformatf("block %0d got/want:", blocks_checked), msg};
      return msg;
    endfunction

    function int pending();
      return due_blocks.size();
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [23:0]                    s_tdata = '0;   // red [7:0], green [15:8], blue [23:16]
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [23:0]                    m_tdata;        // luma [7:0], chroma_blue [15:8], chroma_red [23:16]
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [ryds_pkg::PADDR_W-1:0]   paddr = '0;
  logic [ryds_pkg::PDATA_W-1:0]   pwdata = '0;
  logic [ryds_pkg::PDATA_W-1:0]   prdata;
  logic                           pready;

  rgb_to_ycbcr_2x2_downsample_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  ycbcr_block_tracker tracker = new();

  int          errors = 0;
  int unsigned pixels_sent = 0;
  int unsigned settings_run = 0;
  int unsigned burst_left = 0;
  bit          steady = 1'b0;

  task automatic report(input string msg);
    if (errors < 20) $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  // Receiver: checks accepted block items and stalls to a pattern that changes.
  rx_mode_t    rx_mode = RX_ALWAYS;
  int unsigned rx_mode_left = 0;
  int unsigned rx_run_left = 0;
  logic        rx_run_ready = 1'b1;
  string       rx_msg;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      rx_msg = tracker.check_block(ycc_t'(m_tdata));
      if (rx_msg != "") report(rx_msg);
    end
    if (rx_mode_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(64, 256);
    end else begin
      rx_mode_left--;
    end
    if (rx_run_left == 0) begin
      rx_run_ready = ~rx_run_ready;
      rx_run_left = $urandom_range(1, 12);
    end else begin
      rx_run_left--;
    end
    case (rx_mode)
      RX_ALWAYS: m_tready <= 1'b1;
      RX_RANDOM: m_tready <= ($urandom_range(0, 1) == 1);
      RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
      default:   m_tready <= rx_run_ready;
    endcase
  end

  // Watchdog on cycles in which neither side moves an item.
  int unsigned idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TIMEOUT: no item moved for %0d cycles", IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = steady ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {b, g, r};
    do @(posedge clk); while (!s_tready);
    tracker.note_pixel(r, g, b);
    pixels_sent++;
  endtask

  // Stops the pixel stream and waits until the pipeline has nothing in flight.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_access(input logic idx, input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (wr) tracker.write_register(idx, wdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_register(input logic idx);
    logic [31:0] rdata;
    logic [31:0] want;
    apb_access(idx, 1'b0, 32'd0, rdata);
    want = (idx == ryds_pkg::REG_IMAGE_WIDTH) ? {20'd0, tracker.width_reg}
                                              : {20'd0, tracker.height_reg};
    if (rdata !== want)
      report($sformatf("register %0d read %h, want %h", idx, rdata, want));
  endtask

  // Writes width and height (by chance unless both) with random upper bits, which the registers drop.
  task automatic set_frame(input int unsigned w, input int unsigned h, input bit both);
    logic [31:0] rdata;
    if (both || $urandom_range(0, 1) == 1)
      apb_access(ryds_pkg::REG_IMAGE_WIDTH, 1'b1, ($urandom() & 32'hFFFF_F000) | w, rdata);
    if (both || $urandom_range(0, 1) == 1)
      apb_access(ryds_pkg::REG_IMAGE_HEIGHT, 1'b1, ($urandom() & 32'hFFFF_F000) | h, rdata);
    check_register(ryds_pkg::REG_IMAGE_WIDTH);
    check_register(ryds_pkg::REG_IMAGE_HEIGHT);
    settings_run++;
    steady = ($urandom_range(0, 3) == 0);
  endtask

  task automatic send_random(input int unsigned n, input int unsigned style);
    logic [7:0] r, g, b;
    repeat (n) begin
      case (style)
        0: begin
          r = {8{$urandom_range(0, 1) == 1}};
          g = {8{$urandom_range(0, 1) == 1}};
          b = {8{$urandom_range(0, 1) == 1}};
        end
        1: begin
          r = 8'($urandom_range(96, 160));
          g = 8'(r + $urandom_range(0, 8));
          b = 8'(r - $urandom_range(0, 8));
        end
        default: begin
          r = 8'($urandom());
          g = 8'($urandom());
          b = 8'($urandom());
        end
      endcase
      send_pixel(r, g, b);
    end
  endtask

  initial begin
    int unsigned w, h, n, random_pixels;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values, and a few pixels of a 640x480 frame that form no block.
    check_register(ryds_pkg::REG_IMAGE_WIDTH);
    check_register(ryds_pkg::REG_IMAGE_HEIGHT);
    send_random(6, 2);
    drain();

    // 2x2 frames: black, white, pure blue and pure red blocks.
    set_frame(2, 2, 1'b1);
    repeat (4) send_pixel(8'h00, 8'h00, 8'h00);
    repeat (4) send_pixel(8'hFF, 8'hFF, 8'hFF);
    repeat (4) send_pixel(8'h00, 8'h00, 8'hFF);
    repeat (4) send_pixel(8'hFF, 8'h00, 8'h00);
    drain();

    // Odd width and height: the last column and row are replicated.
    set_frame(3, 3, 1'b1);
    send_pixel(8'h00, 8'hFF, 8'h00);
    send_pixel(8'hFF, 8'h00, 8'hFF);
    send_pixel(8'h00, 8'h00, 8'hFF);
    send_pixel(8'h01, 8'h02, 8'h03);
    send_pixel(8'h80, 8'h80, 8'h80);
    send_pixel(8'hFF, 8'h80, 8'h00);
    send_pixel(8'h00, 8'hFF, 8'hFF);
    send_pixel(8'h7F, 8'h7F, 8'h7F);
    send_pixel(8'hFE, 8'h01, 8'hFE);
    drain();

    // Zero sizes act as one: every pixel forms a block by itself.
    set_frame(0, 0, 1'b1);
    send_random(8, 2);
    drain();

    // Widest rows and tallest columns, and sizes beyond the maximum.
    set_frame(DIM_MAX, 1, 1'b1);
    send_random(40, 2);
    drain();
    set_frame(12'hFFF, 2, 1'b1);
    send_random(40, 2);
    drain();
    set_frame(1, DIM_MAX, 1'b1);
    send_random(40, 2);
    drain();
    set_frame(1, 12'hFFF, 1'b1);
    send_random(40, 2);
    drain();

    // Random frame sizes, mostly small whole frames, some cut short by a write.
    random_pixels = 0;
    while (random_pixels < RANDOM_ITEMS) begin
      w = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 12) : $urandom_range(13, 48);
      h = $urandom_range(1, 6);
      if ($urandom_range(0, 19) == 0) w = 0;
      if ($urandom_range(0, 19) == 0) h = 0;
      set_frame(w, h, $urandom_range(0, 2) != 0);
      n = tracker.clamp_dim(tracker.width_reg) * tracker.clamp_dim(tracker.height_reg);
      n = n * $urandom_range(1, 3);
      if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
      if (n > RANDOM_ITEMS - random_pixels) n = RANDOM_ITEMS - random_pixels;
      send_random(n, $urandom_range(0, 3));
      random_pixels += n;
      drain();
    end

    drain();
    repeat (20) @(posedge clk);
    if (tracker.pending() != 0)
      report($sformatf("%0d predicted block items never arrived", tracker.pending()));
    $display("Sent %0d pixels under %0d frame size settings; %0d block items checked.",
             pixels_sent, settings_run, tracker.blocks_checked);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
